[src/deq_pkg.sv]
// shared types and constants of the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int KIND_W        = 3;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_REAR,
        OP_POP_FRONT,
        OP_POP_REAR,
        OP_LIST
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DATA
    } t_back_state;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        t_status                  status;
        logic                     last;
    } t_res;

endpackage

[src/deq_chan.sv]
// valid/ready channel carrying one item per handshake
interface deq_chan #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[src/deq_front.sv]
// front part: accepts items, decodes the kind and queues commands for the back part
module deq_front (
    input  logic    i_clk,
    input  logic    i_rst_n,
    deq_chan.sink   i_cmd,
    deq_chan.source o_cmd
);

    deq_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    deq_pkg::t_cmd dec_cmd;
    logic          dec_ok;
    logic          push;
    logic          pop;

    always_comb begin
        dec_cmd.value = i_cmd.payload.value;
        dec_cmd.op    = deq_pkg::OP_PUSH_FRONT;
        dec_ok        = 1'b1;
        unique case (i_cmd.payload.kind)
            deq_pkg::KIND_PUSH_FRONT: dec_cmd.op = deq_pkg::OP_PUSH_FRONT;
            deq_pkg::KIND_PUSH_REAR:  dec_cmd.op = deq_pkg::OP_PUSH_REAR;
            deq_pkg::KIND_POP_FRONT:  dec_cmd.op = deq_pkg::OP_POP_FRONT;
            deq_pkg::KIND_POP_REAR:   dec_cmd.op = deq_pkg::OP_POP_REAR;
            deq_pkg::KIND_LIST:       dec_cmd.op = deq_pkg::OP_LIST;
            default:                  dec_ok     = 1'b0;
        endcase
    end

    // unknown kinds are taken and dropped
    assign i_cmd.ready   = (r_count != 2'd2);
    assign push          = i_cmd.valid && i_cmd.ready && dec_ok;
    assign o_cmd.valid   = (r_count != 2'd0);
    assign o_cmd.payload = r_q[r_rd];
    assign pop           = o_cmd.valid && o_cmd.ready;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec_cmd;
        end
    end

endmodule

[src/deq_back.sv]
// back part: ring buffer memory, pointers and result register
module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    deq_chan.sink   i_cmd,
    deq_chan.source o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic signed [deq_pkg::WORD_W-1:0] mem [DEPTH];
    logic signed [deq_pkg::WORD_W-1:0] r_rd_data;

    deq_pkg::t_back_state r_state;
    deq_pkg::t_back_state n_state;

    logic [AW-1:0] r_front;
    logic [AW-1:0] n_front;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] n_occ;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;
    logic [AW-1:0] r_walk;
    logic [AW-1:0] n_walk;

    logic          r_out_valid;
    deq_pkg::t_res r_out;
    deq_pkg::t_res out_item;
    logic          out_load;
    logic          out_free;

    logic          cmd_take;
    logic          is_read;
    logic          empty;
    logic          full;
    logic          rd_start;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] walk_inc;
    logic [AW-1:0] rear_pos;
    logic [AW-1:0] rear_last;
    logic [CW-1:0] occ_dec;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] b, input logic [CW-1:0] o);
        logic [SW-1:0] sum;
        sum = SW'(b) + SW'(o);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        ring_add = sum[AW-1:0];
    endfunction

    assign front_inc = ring_inc(r_front);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign walk_inc  = ring_inc(r_walk);
    assign occ_dec   = r_occ - CW'(1);
    assign rear_pos  = ring_add(r_front, r_occ);
    assign rear_last = ring_add(r_front, occ_dec);

    assign empty    = (r_occ == '0);
    assign full     = (r_occ == CW'(DEPTH));
    assign is_read  = (i_cmd.payload.op == deq_pkg::OP_POP_FRONT)
                   || (i_cmd.payload.op == deq_pkg::OP_POP_REAR)
                   || (i_cmd.payload.op == deq_pkg::OP_LIST);
    assign rd_start = is_read && !empty;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == deq_pkg::S_IDLE) && out_free;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (cmd_take && rd_start) begin
                    n_state = deq_pkg::S_DATA;
                end
            end
            deq_pkg::S_DATA: begin
                if (out_free && (r_left == CW'(1))) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: n_state = deq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_front  = r_front;
        n_occ    = r_occ;
        n_left   = r_left;
        n_walk   = r_walk;
        wr_en    = 1'b0;
        wr_addr  = rear_pos;
        rd_en    = 1'b0;
        rd_addr  = r_walk;
        out_load = 1'b0;
        out_item = '{word: '0, status: deq_pkg::ST_OK, last: 1'b1};
        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (cmd_take) begin
                    out_load = !rd_start;
                    unique case (i_cmd.payload.op)
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
                            if (full) begin
                                out_item.status = deq_pkg::ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                n_occ = r_occ + CW'(1);
                                if (i_cmd.payload.op == deq_pkg::OP_PUSH_FRONT) begin
                                    wr_addr = front_dec;
                                    n_front = front_dec;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                out_item.status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_front = front_inc;
                                n_occ   = occ_dec;
                                n_left  = CW'(1);
                            end
                        end
                        deq_pkg::OP_POP_REAR: begin
                            if (empty) begin
                                out_item.status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = rear_last;
                                n_occ   = occ_dec;
                                n_left  = CW'(1);
                            end
                        end
                        deq_pkg::OP_LIST: begin
                            if (empty) begin
                                out_item.status = deq_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_walk  = front_inc;
                                n_left  = r_occ;
                            end
                        end
                        default: out_load = 1'b0;
                    endcase
                end
            end
            deq_pkg::S_DATA: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_item.word = r_rd_data;
                    out_item.last = (r_left == CW'(1));
                    if (r_left != CW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = r_walk;
                        n_walk  = walk_inc;
                        n_left  = r_left - CW'(1);
                    end
                end
            end
            default: out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::S_IDLE;
            r_front     <= '0;
            r_occ       <= '0;
            r_left      <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
            r_left  <= n_left;
            r_walk  <= n_walk;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_item;
        end
    end

    // ring buffer store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.payload.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + CW'(1))
              || (r_occ == $past(r_occ) - CW'(1)))
        else $error("occupancy moved by more than one");

    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == deq_pkg::S_DATA) |-> (r_left != '0))
        else $error("walk state with nothing left to send");

    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_take && rd_start) |=> (r_state == deq_pkg::S_DATA) && !$past(out_load))
        else $error("read command did not enter walk state");

endmodule

[src/double_ended_queue.sv]
// top level of the bounded double-ended queue
//
//  channel  dir  payload               handshake
//  i_cmd    in   kind, value           valid/ready
//  o_res    out  word, status, last    valid/ready
//
// a push or an empty or full result leaves the back part in the cycle after it takes the item
// a pop reads memory through a register; a listing sends each stored word, front to rear
// a two-entry command queue registers each command and lets input and output stall apart
// synchronous reset empties the queue at once; slot contents stay undefined until written
// the result register holds its item while o_res.ready is low and the back part then waits
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    deq_chan.sink   i_cmd,
    deq_chan.source o_res
);

    deq_chan #(.t_payload(deq_pkg::t_cmd)) u_cmd_chan ();

    deq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_cmd   (u_cmd_chan.source)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_cmd_chan.sink),
        .o_res   (o_res)
    );

endmodule
